>>> rtl/tvb_pkg.sv
// package for the trade volume bucket flow ratio block
// types, codes and constants shared by the controller, datapath and top level
// no dependencies
package tvb_pkg;

    // reset value of both bucket thresholds, notional in q48.16
    localparam logic [63:0] THR_RESET  = 64'd6553600000;

    // q16.16 ratio codes
    localparam logic [31:0] RATIO_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0] RATIO_1000 = 32'h03E8_0000;
    localparam logic [31:0] RATIO_ONE  = 32'h0001_0000;

    // configuration register indexes
    localparam logic REG_BUY_THR  = 1'b0;
    localparam logic REG_SELL_THR = 1'b1;

    // divider: one quotient bit per step
    localparam int          DIV_STEPS = 32;
    localparam int          CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_INIT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic cmp;
        logic init;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic trivial;
        logic out_free;
    } t_sts;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

endpackage

>>> rtl/tvb_ctrl.sv
// controller state machine for the trade volume bucket flow ratio block
// sequences multiply, accumulate, compare, divide and result hand-off
// depends on tvb_pkg
module tvb_ctrl import tvb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.close ? S_INIT : S_IDLE;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.trivial ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_MUL))
        else $error("accepted trade did not start the multiply");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending result");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_LAST) |=> (r_state == S_OUT))
        else $error("divider did not finish after its last step");

endmodule

>>> rtl/tvb_dp.sv
// datapath for the trade volume bucket flow ratio block
// notional multiply, bucket sums, thresholds, bit-serial divider, result register
// depends on tvb_pkg
module tvb_dp import tvb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic [31:0] i_trade_price,
    input  logic [31:0] i_trade_quantity,
    input  logic [63:0] i_trade_time_ns,
    input  logic        i_buyer_aggressor,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_bucket_side,
    output logic [63:0] o_bucket_duration_ns,
    output logic [63:0] o_bucket_threshold,
    output logic [31:0] o_flow_ratio
);

    // latched trade
    logic [31:0] r_price, r_qty;
    logic [63:0] r_ts;
    logic        r_side;
    logic [63:0] r_notional;

    // thresholds and bucket state
    logic [63:0] r_buy_thr, r_sell_thr;
    logic [63:0] r_buy_own, r_buy_opp, r_buy_start;
    logic [63:0] r_sell_own, r_sell_opp, r_sell_start;

    // closing bucket capture and divider
    logic [63:0] r_own, r_dsr, r_dur, r_thr_hold;
    logic [63:0] r_rem;
    logic [31:0] r_dvd, r_quo;

    // result register
    logic        r_out_valid, r_out_side;
    logic [63:0] r_out_dur, r_out_thr;
    logic [31:0] r_out_ratio;

    logic [63:0] w_own_sel, w_opp_sel, w_start_sel, w_thr_sel;
    logic        w_close, w_trivial, w_ge;
    logic [64:0] w_trial, w_diff;

    assign w_own_sel   = r_side ? r_buy_own   : r_sell_own;
    assign w_opp_sel   = r_side ? r_buy_opp   : r_sell_opp;
    assign w_start_sel = r_side ? r_buy_start : r_sell_start;
    assign w_thr_sel   = r_side ? r_buy_thr   : r_sell_thr;
    assign w_close     = (w_own_sel >= w_thr_sel);

    // no opposite flow, or integer part of the ratio at or above 65536
    assign w_trivial = (r_dsr == 64'd0) || ({16'd0, r_own[63:16]} >= r_dsr);

    assign w_trial = {r_rem, r_dvd[31]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    assign o_sts.close    = w_close;
    assign o_sts.trivial  = w_trivial;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // trade capture and multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_price <= i_trade_price;
            r_qty   <= i_trade_quantity;
            r_ts    <= i_trade_time_ns;
            r_side  <= i_buyer_aggressor;
        end
        if (i_cmd.mul) begin
            r_notional <= 64'(r_price) * 64'(r_qty);
        end
    end

    // thresholds and bucket state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buy_thr    <= THR_RESET;
            r_sell_thr   <= THR_RESET;
            r_buy_own    <= '0;
            r_buy_opp    <= '0;
            r_buy_start  <= '0;
            r_sell_own   <= '0;
            r_sell_opp   <= '0;
            r_sell_start <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_BUY_THR:  r_buy_thr  <= i_cfg_data;
                    REG_SELL_THR: r_sell_thr <= i_cfg_data;
                    default:      r_buy_thr  <= r_buy_thr;
                endcase
            end
            if (i_cmd.acc) begin
                if (r_side) begin
                    if (r_buy_start == 64'd0) begin
                        r_buy_start <= r_ts;
                    end
                    r_buy_own  <= sat_add(r_buy_own, r_notional);
                    r_sell_opp <= sat_add(r_sell_opp, r_notional);
                end else begin
                    if (r_sell_start == 64'd0) begin
                        r_sell_start <= r_ts;
                    end
                    r_sell_own <= sat_add(r_sell_own, r_notional);
                    r_buy_opp  <= sat_add(r_buy_opp, r_notional);
                end
            end
            if (i_cmd.cmp && w_close) begin
                if (r_side) begin
                    r_buy_own   <= '0;
                    r_buy_opp   <= '0;
                    r_buy_start <= '0;
                end else begin
                    r_sell_own   <= '0;
                    r_sell_opp   <= '0;
                    r_sell_start <= '0;
                end
            end
        end
    end

    // close capture and restoring divider, one quotient bit a step
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_own      <= w_own_sel;
            r_dsr      <= w_opp_sel;
            r_dur      <= r_ts - w_start_sel;
            r_thr_hold <= w_thr_sel;
        end
        if (i_cmd.init) begin
            r_rem <= {16'd0, r_own[63:16]};
            r_dvd <= {r_own[15:0], 16'd0};
            if (r_dsr == 64'd0) begin
                r_quo <= (r_own != 64'd0) ? RATIO_1000 : RATIO_ONE;
            end else if (w_trivial) begin
                r_quo <= RATIO_MAX;
            end else begin
                r_quo <= '0;
            end
        end
        if (i_cmd.step) begin
            r_rem <= w_ge ? w_diff[63:0] : w_trial[63:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_side  <= r_side;
            r_out_dur   <= r_dur;
            r_out_thr   <= r_thr_hold;
            r_out_ratio <= r_quo;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_bucket_side        = r_out_side;
    assign o_bucket_duration_ns = r_out_dur;
    assign o_bucket_threshold   = r_out_thr;
    assign o_flow_ratio         = r_out_ratio;

endmodule

>>> rtl/trade_volume_bucket_flow_ratio.sv
// top level of the trade volume bucket flow ratio block
// joins the controller and the datapath
// depends on tvb_pkg, tvb_ctrl and tvb_dp
//
// Trades enter one at a time: the block forms the q48.16 notional (price times
// quantity, both q24.8), adds it to the aggressor side's bucket and to the other
// side's opposite flow, and when a bucket reaches its threshold it emits one
// result (side, elapsed time, threshold, q16.16 ratio of own to opposite flow)
// and clears that bucket. A trade that closes no bucket passes through multiply,
// accumulate and compare before the next trade can be taken. A closing trade
// then sets up the divider and skips it when the ratio is a fixed code (no
// opposite flow, or a saturated quotient); otherwise the restoring divider
// yields one quotient bit per cycle. The result sits in an output register, so
// the next trade is taken while it waits; a following close stalls only until
// that register is free. Thresholds must be written through the plain write
// port only while the block is idle; the block itself does not enforce it.
module trade_volume_bucket_flow_ratio import tvb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // trade input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_trade_price,
    input  logic [31:0] i_trade_quantity,
    input  logic [63:0] i_trade_time_ns,
    input  logic        i_buyer_aggressor,
    // bucket result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_bucket_side,
    output logic [63:0] o_bucket_duration_ns,
    output logic [63:0] o_bucket_threshold,
    output logic [31:0] o_flow_ratio
);

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    tvb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    tvb_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_trade_price        (i_trade_price),
        .i_trade_quantity     (i_trade_quantity),
        .i_trade_time_ns      (i_trade_time_ns),
        .i_buyer_aggressor    (i_buyer_aggressor),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_bucket_side        (o_bucket_side),
        .o_bucket_duration_ns (o_bucket_duration_ns),
        .o_bucket_threshold   (o_bucket_threshold),
        .o_flow_ratio         (o_flow_ratio)
    );

endmodule
